// ===== rtl/core/rsa_modular_exponentiation_core_defines.svh =====
// Assertion macros shared by the modular exponentiation core files.
`ifndef RSA_MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define RSA_MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rsa_me_pkg.sv =====
// Package with the shared types and constants of the modular exponentiation core.
`default_nettype none

package rsa_me_pkg;

    localparam int BASE_WIDTH  = 31;
    localparam int BYTE_WIDTH  = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [BYTE_WIDTH-1:0] BYTE_MASK = 8'hFF;

    localparam logic ACTION_ENCRYPT = 1'b0;
    localparam logic ACTION_DECRYPT = 1'b1;
    localparam logic KEY_PRIVATE    = 1'b0;
    localparam logic KEY_PUBLIC     = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_PRIVATE_EXPONENT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRIVATE_MODULUS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PUBLIC_EXPONENT  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PUBLIC_MODULUS   = 8'd3;

    localparam logic [31:0] RESET_PRIVATE_EXPONENT = 32'd2753;
    localparam logic [31:0] RESET_PRIVATE_MODULUS  = 32'd3233;
    localparam logic [31:0] RESET_PUBLIC_EXPONENT  = 32'd17;
    localparam logic [31:0] RESET_PUBLIC_MODULUS   = 32'd3233;

    localparam logic [31:0] MIN_MODULUS = 32'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

`default_nettype wire

// ===== rtl/core/rsa_me_if.sv =====
// Handshake interfaces for the input, result and configuration channels.
`default_nettype none

interface rsa_me_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic                             key_select;
    logic [rsa_me_pkg::BASE_WIDTH-1:0] base_value;
    logic                             last_in;

    modport source (output valid, output action, output key_select,
                    output base_value, output last_in, input ready);
    modport sink   (input valid, input action, input key_select,
                    input base_value, input last_in, output ready);
endinterface

interface rsa_me_out_if #(parameter int MODULUS_WIDTH = 20);
    logic                     valid;
    logic                     ready;
    logic [MODULUS_WIDTH-1:0] residue;
    logic                     last_out;

    modport source (output valid, output residue, output last_out, input ready);
    modport sink   (input valid, input residue, input last_out, output ready);
endinterface

interface rsa_me_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rsa_me_pkg::CFG_INDEX_W-1:0] index;
    logic [rsa_me_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rsa_me_modmul.sv =====
// Bit-serial modular multiplier, one multiplier bit per cycle.
`default_nettype none
`include "rsa_modular_exponentiation_core_defines.svh"

module rsa_me_modmul #(
    parameter int MW = 20,
    parameter int BW = 31,
    parameter int CW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [MW-1:0] i_a,
    input  wire logic [BW-1:0] i_b,
    input  wire logic [CW-1:0] i_nbits,
    input  wire logic [MW-1:0] i_m,
    output rsa_me_pkg::t_mm_stat o_stat,
    output logic [MW-1:0]      o_result
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [MW-1:0] r_r, n_r;
    logic [MW-1:0] r_a, n_a;
    logic [BW-1:0] r_b, n_b;
    logic [MW-1:0] r_m, n_m;

    logic [MW+1:0] w_t, w_m1, w_m2, w_red;

    // The partial result stays below m, so 2r + a stays below 3m.
    always_comb begin
        w_t  = {1'b0, r_r, 1'b0} + (r_b[BW-1] ? {2'b00, r_a} : {(MW+2){1'b0}});
        w_m1 = {2'b00, r_m};
        w_m2 = {1'b0, r_m, 1'b0};
        if (w_t >= w_m2) begin
            w_red = w_t - w_m2;
        end else if (w_t >= w_m1) begin
            w_red = w_t - w_m1;
        end else begin
            w_red = w_t;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_r    = r_r;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_nbits;
            n_r    = {MW{1'b0}};
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
        end else if (r_busy) begin
            n_r   = w_red[MW-1:0];
            n_b   = r_b << 1;
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_r   <= n_r;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_r;

    `RSA_ASSERT_SAME(a_mm_done_idle, i_clk, i_rst_n, r_done, !r_busy, "done while busy")
    `RSA_ASSERT_SAME(a_mm_partial_lt_m, i_clk, i_rst_n, r_busy, r_r < r_m, "partial not reduced")
    `RSA_ASSERT_SAME(a_mm_cnt_live, i_clk, i_rst_n, r_busy, r_cnt != {CW{1'b0}},
        "busy with zero count")
    `RSA_ASSERT_NEXT(a_mm_start_busy, i_clk, i_rst_n, i_start, r_busy, "start did not run")

endmodule

`default_nettype wire

// ===== rtl/core/rsa_me_regs.sv =====
// Key register file with write decode for the configuration channel.
`default_nettype none

module rsa_me_regs #(
    parameter int MW = 20,
    parameter int EW = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rsa_me_cfg_if.sink         i_cfg,
    output logic [EW-1:0]      o_private_exponent,
    output logic [MW-1:0]      o_private_modulus,
    output logic [EW-1:0]      o_public_exponent,
    output logic [MW-1:0]      o_public_modulus
);

    logic [EW-1:0] r_private_exponent;
    logic [MW-1:0] r_private_modulus;
    logic [EW-1:0] r_public_exponent;
    logic [MW-1:0] r_public_modulus;

    assign i_cfg.ready = 1'b1;

    // Writes to an index beyond the four key registers are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_private_exponent <= EW'(rsa_me_pkg::RESET_PRIVATE_EXPONENT);
            r_private_modulus  <= MW'(rsa_me_pkg::RESET_PRIVATE_MODULUS);
            r_public_exponent  <= EW'(rsa_me_pkg::RESET_PUBLIC_EXPONENT);
            r_public_modulus   <= MW'(rsa_me_pkg::RESET_PUBLIC_MODULUS);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rsa_me_pkg::REG_PRIVATE_EXPONENT: r_private_exponent <= EW'(i_cfg.data);
                rsa_me_pkg::REG_PRIVATE_MODULUS:  r_private_modulus  <= MW'(i_cfg.data);
                rsa_me_pkg::REG_PUBLIC_EXPONENT:  r_public_exponent  <= EW'(i_cfg.data);
                rsa_me_pkg::REG_PUBLIC_MODULUS:   r_public_modulus   <= MW'(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    assign o_private_exponent = r_private_exponent;
    assign o_private_modulus  = r_private_modulus;
    assign o_public_exponent  = r_public_exponent;
    assign o_public_modulus   = r_public_modulus;

endmodule

`default_nettype wire

// ===== rtl/core/rsa_modular_exponentiation_core.sv =====
// Top level of the square-and-multiply modular exponentiation core.
//
//   Channel    Dir  Payload                                   Accepted when
//   i_item     in   action, key_select, base_value, last_in   valid && ready
//   o_result   out  residue, last_out                         valid && ready
//   i_cfg      in   index, data                               valid && ready
//
// From acceptance an item first has its base reduced mod m; then the exponent bits are
// scanned from the top, and each bit below the top set bit takes a squaring and, if set,
// a multiply. All arithmetic runs on the single bit-serial modular multiplier, one
// multiplier bit per cycle.
// Reset is synchronous and active low; it idles the sequencer and loads the default keys.
// Input is ready only while idle; a result held at the output stalls the next finish.
`default_nettype none
`include "rsa_modular_exponentiation_core_defines.svh"

module rsa_modular_exponentiation_core #(
    parameter int MODULUS_WIDTH  = 20,
    parameter int EXPONENT_WIDTH = 31
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rsa_me_in_if.sink       i_item,
    rsa_me_out_if.source    o_result,
    rsa_me_cfg_if.sink      i_cfg
);

    localparam int MW  = MODULUS_WIDTH;
    localparam int EW  = EXPONENT_WIDTH;
    localparam int BAW = rsa_me_pkg::BASE_WIDTH;
    // The multiplier operand register must hold either a residue or a raw base.
    localparam int BW  = (MW > BAW) ? MW : BAW;
    localparam int CW  = $clog2(BW + 1);
    localparam int EBW = $clog2(EW + 1);
    localparam int SH_RES  = BW - MW;
    localparam int SH_BASE = BW - BAW;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_REDUCE = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_SQR    = 3'd4;
    localparam logic [2:0] ST_MUL    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [EW-1:0] w_private_exponent, w_public_exponent, w_sel_exp;
    logic [MW-1:0] w_private_modulus, w_public_modulus, w_sel_mod;

    logic [2:0]     r_state, n_state;
    logic [EW-1:0]  r_exp, n_exp;
    logic [EBW-1:0] r_bitcnt, n_bitcnt;
    logic [MW-1:0]  r_mod, n_mod;
    logic [BAW-1:0] r_base_in, n_base_in;
    logic [MW-1:0]  r_base, n_base;
    logic [MW-1:0]  r_acc, n_acc;
    logic           r_started, n_started;
    logic           r_bit, n_bit;
    logic           r_decrypt, n_decrypt;
    logic           r_last, n_last;
    logic           r_out_valid, n_out_valid;
    logic [MW-1:0]  r_out_residue, n_out_residue;
    logic           r_out_last, n_out_last;

    logic                 mm_start;
    logic [MW-1:0]        mm_a;
    logic [BW-1:0]        mm_b;
    logic [CW-1:0]        mm_nbits;
    rsa_me_pkg::t_mm_stat mm_stat;
    logic [MW-1:0]        mm_result;

    rsa_me_regs #(
        .MW (MW),
        .EW (EW)
    ) u_regs (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (i_cfg),
        .o_private_exponent (w_private_exponent),
        .o_private_modulus  (w_private_modulus),
        .o_public_exponent  (w_public_exponent),
        .o_public_modulus   (w_public_modulus)
    );

    rsa_me_modmul #(
        .MW (MW),
        .BW (BW),
        .CW (CW)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_nbits  (mm_nbits),
        .i_m      (r_mod),
        .o_stat   (mm_stat),
        .o_result (mm_result)
    );

    assign w_sel_exp = (i_item.key_select == rsa_me_pkg::KEY_PUBLIC) ?
                       w_public_exponent : w_private_exponent;
    assign w_sel_mod = (i_item.key_select == rsa_me_pkg::KEY_PUBLIC) ?
                       w_public_modulus : w_private_modulus;

    assign i_item.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state       = r_state;
        n_exp         = r_exp;
        n_bitcnt      = r_bitcnt;
        n_mod         = r_mod;
        n_base_in     = r_base_in;
        n_base        = r_base;
        n_acc         = r_acc;
        n_started     = r_started;
        n_bit         = r_bit;
        n_decrypt     = r_decrypt;
        n_last        = r_last;
        n_out_valid   = r_out_valid;
        n_out_residue = r_out_residue;
        n_out_last    = r_out_last;
        mm_start      = 1'b0;
        mm_a          = MW'(1);
        mm_b          = BW'(r_base_in) << SH_BASE;
        mm_nbits      = CW'(BAW);

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_exp     = w_sel_exp;
                    n_mod     = w_sel_mod;
                    n_decrypt = i_item.action;
                    n_last    = i_item.last_in;
                    n_acc     = MW'(1);
                    n_started = 1'b0;
                    n_bitcnt  = EBW'(EW);
                    // An encrypt item carries a message byte in the low bits only.
                    if (i_item.action == rsa_me_pkg::ACTION_DECRYPT) begin
                        n_base_in = i_item.base_value;
                    end else begin
                        n_base_in = i_item.base_value & BAW'(rsa_me_pkg::BYTE_MASK);
                    end
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                // A modulus below two gives a zero residue without any arithmetic.
                if (r_mod < MW'(rsa_me_pkg::MIN_MODULUS)) begin
                    n_acc   = {MW{1'b0}};
                    n_state = ST_FINISH;
                end else begin
                    // Reduce the base as 1 * base mod m, scanning all base bits.
                    mm_start = 1'b1;
                    n_state  = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mm_stat.done) begin
                    n_base  = mm_result;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_bitcnt == {EBW{1'b0}}) begin
                    n_state = ST_FINISH;
                end else begin
                    n_exp    = {r_exp[EW-2:0], 1'b0};
                    n_bitcnt = r_bitcnt - EBW'(1);
                    if (!r_started) begin
                        // Squaring one is a no-op, so leading zero bits are skipped
                        // and the top set bit loads the reduced base directly.
                        if (r_exp[EW-1]) begin
                            n_acc     = r_base;
                            n_started = 1'b1;
                        end
                    end else begin
                        n_bit    = r_exp[EW-1];
                        mm_start = 1'b1;
                        mm_a     = r_acc;
                        mm_b     = BW'(r_acc) << SH_RES;
                        mm_nbits = CW'(MW);
                        n_state  = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (mm_stat.done) begin
                    n_acc = mm_result;
                    if (r_bit) begin
                        mm_start = 1'b1;
                        mm_a     = mm_result;
                        mm_b     = BW'(r_base) << SH_RES;
                        mm_nbits = CW'(MW);
                        n_state  = ST_MUL;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_MUL: begin
                if (mm_stat.done) begin
                    n_acc   = mm_result;
                    n_state = ST_SCAN;
                end
            end
            ST_FINISH: begin
                // Hold here until the output register is free.
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_last  = r_last;
                    if (r_decrypt == rsa_me_pkg::ACTION_DECRYPT) begin
                        n_out_residue = r_acc & MW'(rsa_me_pkg::BYTE_MASK);
                    end else begin
                        n_out_residue = r_acc;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_exp         <= n_exp;
        r_bitcnt      <= n_bitcnt;
        r_mod         <= n_mod;
        r_base_in     <= n_base_in;
        r_base        <= n_base;
        r_acc         <= n_acc;
        r_started     <= n_started;
        r_bit         <= n_bit;
        r_decrypt     <= n_decrypt;
        r_last        <= n_last;
        r_out_residue <= n_out_residue;
        r_out_last    <= n_out_last;
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.residue  = r_out_residue;
    assign o_result.last_out = r_out_last;

    `RSA_ASSERT_SAME(a_acc_reduced, i_clk, i_rst_n, r_state == ST_SCAN, r_acc < r_mod,
        "running value not reduced")
    `RSA_ASSERT_SAME(a_start_when_free, i_clk, i_rst_n, mm_start, !mm_stat.busy,
        "multiplier started while busy")
    `RSA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_item.valid && i_item.ready,
        r_state == ST_PREP, "accepted item not taken up")
    `RSA_ASSERT_NEXT(a_finish_delivers, i_clk, i_rst_n,
        (r_state == ST_FINISH) && (!r_out_valid || o_result.ready), r_out_valid,
        "finished item not presented")

endmodule

`default_nettype wire
